FILE: src/gafs_pkg.sv
// ----------------------------------------------------------------------------
// Genotype allele frequency shaper package
// Shared widths, codes and record types for the shaper pipeline.
// ----------------------------------------------------------------------------
package gafs_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int FRAC_BITS   = 16;

  // Genotype total and allele counts need two more bits, the allele total three.
  localparam int GT_TOT_W = COUNT_WIDTH + 2;
  localparam int AL_W     = COUNT_WIDTH + 2;
  localparam int NUM_W    = COUNT_WIDTH + 3;

  localparam int PCT_SCALE = 100;
  localparam int MUL_W     = $clog2(PCT_SCALE + 1);
  // The numerator never exceeds its denominator, so a quotient is at most
  // PCT_SCALE * 2^FRAC_BITS.
  localparam int QUO_W     = MUL_W + FRAC_BITS;
  localparam int THR_W     = FRAC_BITS + 1;
  localparam int PROD_W    = THR_W + NUM_W;
  localparam int VALUE_W   = 44;

  localparam int CODE_W     = 4;
  localparam int KIND_W     = 2;
  localparam int NUM_CODES  = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [THR_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [CODE_W-1:0] {
    CODE_GT_HOMREF,
    CODE_GT_HET,
    CODE_GT_HOMALT,
    CODE_GT_MISSING,
    CODE_GT_TOTAL,
    CODE_AL_REF,
    CODE_AL_ALT,
    CODE_AL_MISSING,
    CODE_AL_TOTAL
  } code_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ABS,
    KIND_FRAC,
    KIND_PCT
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ABSOLUTE_MASK,
    REG_SECTION_MASK,
    REG_INCLUDE_TOTALS,
    REG_PERCENT_SCALE,
    REG_EXTRAPOLATE,
    REG_MIN_FREQ_AL,
    REG_MIN_FREQ_GT
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]       absolute_mask;
    logic [1:0]       section_mask;
    logic             include_totals;
    logic             percent_scale;
    logic             extrapolate;
    logic [THR_W-1:0] min_freq_al;
    logic [THR_W-1:0] min_freq_gt;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] g0;
    logic [COUNT_WIDTH-1:0] g1;
    logic [COUNT_WIDTH-1:0] g2;
    logic [COUNT_WIDTH-1:0] g3;
    logic [AL_W-1:0]        a0;
    logic [AL_W-1:0]        a1;
    logic [AL_W-1:0]        a2;
    logic [GT_TOT_W-1:0]    tot_gt;
    logic [NUM_W-1:0]       tot_al;
    logic [NUM_W-1:0]       den_al;
    logic                   na;
  } item_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    logic             rel;
    code_t            code;
    kind_t            kind;
    logic             na;
    logic             last;
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [NUM_W-1:0] r;
    logic [QUO_W-1:0] q;
    logic [MUL_W-1:0] low;
  } dstage_t;

endpackage

FILE: src/gafs_front.sv
// ----------------------------------------------------------------------------
// Shaper front end
// Four stages: genotype sums, allele totals, threshold products, filter test.
// ----------------------------------------------------------------------------
module gafs_front (
  input  logic                             clk,
  input  logic                             rst,
  input  gafs_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [gafs_pkg::COUNT_WIDTH-1:0] count_homref,
  input  logic [gafs_pkg::COUNT_WIDTH-1:0] count_het,
  input  logic [gafs_pkg::COUNT_WIDTH-1:0] count_homalt,
  input  logic [gafs_pkg::COUNT_WIDTH-1:0] count_missing,
  output logic                             out_valid,
  input  logic                             out_ready,
  output gafs_pkg::item_t                  out_item
);
  import gafs_pkg::*;

  logic              v1, v2, v3, v4;
  logic              rdy1, rdy2, rdy3, rdy4;
  item_t             s1, s2, s3, s4;
  item_t             s1_next, s2_next, s4_next;
  logic [PROD_W-1:0] p_al, p_gt;
  logic [PROD_W-1:0] p_al_next, p_gt_next;
  logic              act_al, act_gt, trip_al, trip_gt;

  function automatic logic below(logic [NUM_W-1:0] num, logic [NUM_W-1:0] den,
                                 logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0] lhs;
    lhs = PROD_W'({num, {FRAC_BITS{1'b0}}});
    return (den != '0) && (lhs < prod);
  endfunction

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s1_next        = '0;
    s1_next.g0     = count_homref;
    s1_next.g1     = count_het;
    s1_next.g2     = count_homalt;
    s1_next.g3     = count_missing;
    s1_next.a0     = AL_W'({count_homref, 1'b0}) + AL_W'(count_het);
    s1_next.a1     = AL_W'({count_homalt, 1'b0}) + AL_W'(count_het);
    s1_next.a2     = AL_W'({count_missing, 1'b0});
    s1_next.tot_gt = GT_TOT_W'(count_homref) + GT_TOT_W'(count_het)
                   + GT_TOT_W'(count_homalt) + GT_TOT_W'(count_missing);
  end

  always_comb begin
    s2_next        = s1;
    s2_next.tot_al = NUM_W'(s1.a0) + NUM_W'(s1.a1) + NUM_W'(s1.a2);
    s2_next.den_al = cfg.extrapolate ? NUM_W'(s1.a0) + NUM_W'(s1.a1) : s2_next.tot_al;
  end

  assign p_al_next = PROD_W'(cfg.min_freq_al) * PROD_W'(s2.den_al);
  assign p_gt_next = PROD_W'(cfg.min_freq_gt) * PROD_W'(s2.tot_gt);

  // A threshold above one disables its filter.
  assign act_al  = cfg.min_freq_al <= ONE_Q;
  assign act_gt  = cfg.min_freq_gt <= ONE_Q;
  assign trip_al = below(NUM_W'(s3.a0), s3.den_al, p_al)
                || below(NUM_W'(s3.a1), s3.den_al, p_al);
  assign trip_gt = below(NUM_W'(s3.g0), NUM_W'(s3.tot_gt), p_gt)
                || below(NUM_W'(s3.g1), NUM_W'(s3.tot_gt), p_gt)
                || below(NUM_W'(s3.g2), NUM_W'(s3.tot_gt), p_gt);

  always_comb begin
    s4_next    = s3;
    s4_next.na = (act_al && trip_al) || (act_gt && trip_gt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1 <= s1_next;
    if (rdy2 && v1) s2 <= s2_next;
    if (rdy3 && v2) begin
      s3   <= s2;
      p_al <= p_al_next;
      p_gt <= p_gt_next;
    end
    if (rdy4 && v3) s4 <= s4_next;
  end

  assign out_valid = v4;
  assign out_item  = s4;

endmodule

FILE: src/gafs_seq.sv
// ----------------------------------------------------------------------------
// Shaper result sequencer
// Holds one variant and issues its result requests in code order, one per cycle while op_ready is high.
// ----------------------------------------------------------------------------
module gafs_seq (
  input  logic            clk,
  input  logic            rst,
  input  gafs_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  gafs_pkg::item_t in_item,
  output logic            op_valid,
  input  logic            op_ready,
  output gafs_pkg::op_t   op
);
  import gafs_pkg::*;

  logic [NUM_CODES-1:0] pend, pend_next, lowbit, emit_mask;
  item_t                it;
  code_t                cur;
  logic                 fire;

  always_comb begin
    emit_mask    = '0;
    emit_mask[0] = cfg.section_mask[0];
    emit_mask[1] = cfg.section_mask[0];
    emit_mask[2] = cfg.section_mask[0];
    emit_mask[3] = cfg.section_mask[0] && !cfg.absolute_mask[0];
    emit_mask[4] = cfg.section_mask[0] && cfg.include_totals;
    emit_mask[5] = cfg.section_mask[1];
    emit_mask[6] = cfg.section_mask[1];
    emit_mask[7] = cfg.section_mask[1];
    emit_mask[8] = cfg.section_mask[1] && cfg.include_totals;
  end

  assign lowbit = pend & (~pend + NUM_CODES'(1));

  always_comb begin
    cur = CODE_GT_HOMREF;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (lowbit[i]) cur = code_t'(CODE_W'(i));
    end
  end

  assign op_valid  = pend != '0;
  assign fire      = op_valid && op_ready;
  assign pend_next = fire ? (pend & ~lowbit) : pend;
  assign in_ready  = pend_next == '0;

  always_comb begin
    op      = '0;
    op.code = cur;
    unique case (cur)
      CODE_GT_HOMREF: begin
        op.num = NUM_W'(it.g0);
        op.den = NUM_W'(it.tot_gt);
        op.rel = !cfg.absolute_mask[0];
      end
      CODE_GT_HET: begin
        op.num = NUM_W'(it.g1);
        op.den = NUM_W'(it.tot_gt);
        op.rel = !cfg.absolute_mask[0];
      end
      CODE_GT_HOMALT: begin
        op.num = NUM_W'(it.g2);
        op.den = NUM_W'(it.tot_gt);
        op.rel = !cfg.absolute_mask[0];
      end
      CODE_GT_MISSING: begin
        op.num = NUM_W'(it.g3);
        op.den = NUM_W'(it.tot_gt);
        op.rel = 1'b1;
      end
      CODE_GT_TOTAL: begin
        op.num = NUM_W'(it.tot_gt);
      end
      CODE_AL_REF: begin
        op.num = NUM_W'(it.a0);
        op.den = it.den_al;
        op.rel = !cfg.absolute_mask[1];
      end
      CODE_AL_ALT: begin
        op.num = NUM_W'(it.a1);
        op.den = it.den_al;
        op.rel = !cfg.absolute_mask[1];
      end
      CODE_AL_MISSING: begin
        op.num = NUM_W'(it.a2);
        op.den = it.tot_al;
        op.rel = !cfg.absolute_mask[1];
      end
      CODE_AL_TOTAL: begin
        op.num = it.tot_al;
      end
      default: begin
        op.num = '0;
      end
    endcase
    op.kind = !op.rel ? KIND_ABS : (cfg.percent_scale ? KIND_PCT : KIND_FRAC);
    op.na   = it.na || (op.rel && op.den == '0);
    op.last = (pend & ~lowbit) == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (in_valid && in_ready) begin
      pend <= emit_mask;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) it <= in_item;
  end

endmodule

FILE: src/gafs_div.sv
// ----------------------------------------------------------------------------
// Shaper scaling divider
// Scale stage, one restoring quotient bit per stage, and the result register.
// ----------------------------------------------------------------------------
module gafs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gafs_pkg::op_t                in_op,
  output logic                         out_valid,
  input  logic                         stall,
  output logic [gafs_pkg::VALUE_W-1:0] value,
  output logic [gafs_pkg::CODE_W-1:0]  code,
  output logic [gafs_pkg::KIND_W-1:0]  kind,
  output logic                         na,
  output logic                         last
);
  import gafs_pkg::*;

  localparam int NST = QUO_W + 1;

  logic                     v [NST];
  logic                     rdy [NST];
  dstage_t                  st [NST];
  dstage_t                  st0_next;
  logic [NUM_W+MUL_W-1:0]   prod;
  logic [MUL_W-1:0]         mulc;
  logic                     rdy_o;
  logic                     ov;
  logic [VALUE_W-1:0]       o_value;
  code_t                    o_code;
  kind_t                    o_kind;
  logic                     o_na, o_last;

  function automatic dstage_t div_step(dstage_t s);
    logic [NUM_W:0] t;
    dstage_t        n;
    n     = s;
    t     = {s.r, s.low[MUL_W-1]};
    n.low = s.low << 1;
    if (t >= {1'b0, s.op.den}) begin
      n.r = NUM_W'(t - {1'b0, s.op.den});
      n.q = {s.q[QUO_W-2:0], 1'b1};
    end else begin
      n.r = t[NUM_W-1:0];
      n.q = {s.q[QUO_W-2:0], 1'b0};
    end
    return n;
  endfunction

  assign rdy_o = !ov || !stall;

  always_comb begin
    rdy[NST-1] = !v[NST-1] || rdy_o;
    for (int s = NST - 2; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  assign in_ready = rdy[0];

  // The top part of the scaled numerator is already below the denominator,
  // so only the low scale bits and the fraction zeros are shifted in.
  assign mulc = (in_op.kind == KIND_PCT) ? MUL_W'(PCT_SCALE) : MUL_W'(1);
  assign prod = (NUM_W+MUL_W)'(in_op.num) * (NUM_W+MUL_W)'(mulc);

  always_comb begin
    st0_next.op  = in_op;
    st0_next.r   = prod[NUM_W+MUL_W-1:MUL_W];
    st0_next.low = prod[MUL_W-1:0];
    st0_next.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) v[s] <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int s = 1; s < NST; s++) begin
        if (rdy[s]) v[s] <= v[s-1];
      end
      if (rdy_o) ov <= v[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) st[0] <= st0_next;
    for (int s = 1; s < NST; s++) begin
      if (rdy[s] && v[s-1]) st[s] <= div_step(st[s-1]);
    end
    if (rdy_o && v[NST-1]) begin
      if (st[NST-1].op.na) begin
        o_value <= '0;
      end else if (st[NST-1].op.rel) begin
        o_value <= VALUE_W'(st[NST-1].q);
      end else begin
        o_value <= VALUE_W'(st[NST-1].op.num);
      end
      o_code <= st[NST-1].op.code;
      o_kind <= st[NST-1].op.kind;
      o_na   <= st[NST-1].op.na;
      o_last <= st[NST-1].op.last;
    end
  end

  assign out_valid = ov;
  assign value     = o_value;
  assign code      = o_code;
  assign kind      = o_kind;
  assign na        = o_na;
  assign last      = o_last;

endmodule

FILE: src/genotype_allele_frequency_shaper.sv
// ----------------------------------------------------------------------------
// Genotype allele frequency shaper
// Turns one variant's genotype counts into a run of count and frequency results.
// ----------------------------------------------------------------------------
//   Channel   Signals                                Direction
//   item      item_valid, item_stall, count_*         in
//   result    result_valid, result_stall, value,      out
//             item_code, value_kind, is_na, last
//   config    cfg_valid, cfg_ready, cfg_index,        in
//             cfg_data
//
// The sequencer holds a variant while it issues its n results, n being its result
// count (at most nine); results leave at one per cycle while result_stall is low,
// and the result channel sets the variant rate. A request reaches its first result
// through four front stages, the sequencer, a scale stage, one stage per quotient bit
// and the result register. Reset restores the register defaults and empties
// the pipeline. A result stall holds only the full stages, so bubbles close up.
module genotype_allele_frequency_shaper (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [gafs_pkg::COUNT_WIDTH-1:0] count_homref,
  input  logic [gafs_pkg::COUNT_WIDTH-1:0] count_het,
  input  logic [gafs_pkg::COUNT_WIDTH-1:0] count_homalt,
  input  logic [gafs_pkg::COUNT_WIDTH-1:0] count_missing,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [gafs_pkg::VALUE_W-1:0]     value,
  output logic [gafs_pkg::CODE_W-1:0]      item_code,
  output logic [gafs_pkg::KIND_W-1:0]      value_kind,
  output logic                             is_na,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gafs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gafs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gafs_pkg::*;

  cfg_t  cfg;
  logic  front_ready, item_ok, seq_ready, op_valid, op_ready;
  item_t item;
  op_t   op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.absolute_mask  <= 2'd0;
      cfg.section_mask   <= 2'd1;
      cfg.include_totals <= 1'b1;
      cfg.percent_scale  <= 1'b0;
      cfg.extrapolate    <= 1'b1;
      cfg.min_freq_al    <= '0;
      cfg.min_freq_gt    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ABSOLUTE_MASK:  cfg.absolute_mask  <= cfg_data[1:0];
        REG_SECTION_MASK:   cfg.section_mask   <= cfg_data[1:0];
        REG_INCLUDE_TOTALS: cfg.include_totals <= cfg_data[0];
        REG_PERCENT_SCALE:  cfg.percent_scale  <= cfg_data[0];
        REG_EXTRAPOLATE:    cfg.extrapolate    <= cfg_data[0];
        REG_MIN_FREQ_AL:    cfg.min_freq_al    <= cfg_data[THR_W-1:0];
        REG_MIN_FREQ_GT:    cfg.min_freq_gt    <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item_stall = !front_ready;

  gafs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (item_valid),
    .in_ready      (front_ready),
    .count_homref  (count_homref),
    .count_het     (count_het),
    .count_homalt  (count_homalt),
    .count_missing (count_missing),
    .out_valid     (item_ok),
    .out_ready     (seq_ready),
    .out_item      (item)
  );

  gafs_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (item_ok),
    .in_ready (seq_ready),
    .in_item  (item),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  gafs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (op_valid),
    .in_ready  (op_ready),
    .in_op     (op),
    .out_valid (result_valid),
    .stall     (result_stall),
    .value     (value),
    .code      (item_code),
    .kind      (value_kind),
    .na        (is_na),
    .last      (last)
  );

endmodule

FILE: src/gafs_checker.sv
// ----------------------------------------------------------------------------
// Shaper port checker
// Watches the top level's ports for result channel and result content rules.
// ----------------------------------------------------------------------------
module gafs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic [gafs_pkg::VALUE_W-1:0]     value,
  input logic [gafs_pkg::CODE_W-1:0]      item_code,
  input logic [gafs_pkg::KIND_W-1:0]      value_kind,
  input logic                             is_na
);
  import gafs_pkg::*;

  // A stalled result request stays and keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(value))
    else $error("result request dropped or changed under stall");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result request right after reset");

  a_na_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_na |-> value == '0)
    else $error("unavailable result carries a nonzero value");

  a_total_abs: assert property (@(posedge clk) disable iff (rst)
    result_valid && (item_code == CODE_GT_TOTAL || item_code == CODE_AL_TOTAL)
      |-> value_kind == KIND_ABS)
    else $error("total reported as a relative value");

  // A relative value fits in the quotient width, which holds the percent scale in fixed point.
  a_rel_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && value_kind != KIND_ABS |-> value[VALUE_W-1:QUO_W] == '0)
    else $error("relative value out of range");

endmodule

bind genotype_allele_frequency_shaper gafs_checker u_gafs_checker (.*);

FILE: tb/tb_genotype_allele_frequency_shaper.sv
// ----------------------------------------------------------------------------
// Genotype allele frequency shaper testbench
// Sends variant genotype counts under a series of register settings, predicts
// each run of count and frequency results, and checks them in order while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_genotype_allele_frequency_shaper;
  import gafs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASES         = 15;
  localparam int PHASE_ITEMS    = 30;

  typedef struct {
    logic [VALUE_W-1:0] value;
    code_t              code;
    kind_t              kind;
    logic               na;
    logic               last;
  } freq_result_t;

  typedef struct {
    int unsigned homref, het, homalt, missing;
    bit          checked;
    logic        exp_na;
    longint      exp_value;
  } variant_row_t;

  logic clk, rst;
  logic item_valid, item_stall, result_valid, result_stall;
  logic [COUNT_WIDTH-1:0] count_homref, count_het, count_homalt, count_missing;
  logic [VALUE_W-1:0] value;
  logic [CODE_W-1:0]  item_code;
  logic [KIND_W-1:0]  value_kind;
  logic is_na, last, cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  genotype_allele_frequency_shaper dut (.*);

  cfg_t         shaper_cfg;
  freq_result_t pending_results[$];
  int           mismatches = 0;
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;
  int           quiet_cycles = 0;
  // Queue position of the first result of the most recently predicted run.
  int           run_first = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic bit frac_below(longint unsigned num, longint unsigned den,
                                    longint unsigned thr);
    if (den == 0) return 1'b0;
    return (num << FRAC_BITS) < thr * den;
  endfunction

  function automatic void add_result(longint unsigned v, code_t code, kind_t kind,
                                     bit na);
    freq_result_t r;
    r.value = na ? '0 : v[VALUE_W-1:0];
    r.code  = code;
    r.kind  = kind;
    r.na    = na;
    r.last  = 1'b0;
    pending_results = {pending_results, r};
  endfunction

  function automatic void push_relative(longint unsigned num, longint unsigned den,
                                        code_t code, bit na);
    kind_t           kind;
    longint unsigned mul;
    kind = shaper_cfg.percent_scale ? KIND_PCT : KIND_FRAC;
    mul  = shaper_cfg.percent_scale ? PCT_SCALE : 1;
    if (na || den == 0) add_result(0, code, kind, 1'b1);
    else add_result(((num * mul) << FRAC_BITS) / den, code, kind, 1'b0);
  endfunction

  // Appends the whole run of results that one variant produces.
  function automatic void predict_frequencies(int unsigned h, int unsigned t,
                                              int unsigned ha, int unsigned m);
    longint unsigned g0, g1, g2, g3, a0, a1, a2, tot_gt, tot_al, den_al, one;
    bit na;
    int first;
    g0 = h; g1 = t; g2 = ha; g3 = m;
    one = longint'(1) << FRAC_BITS;
    a0 = 2 * g0 + g1;
    a1 = 2 * g2 + g1;
    a2 = 2 * g3;
    tot_gt = g0 + g1 + g2 + g3;
    tot_al = a0 + a1 + a2;
    den_al = shaper_cfg.extrapolate ? a0 + a1 : tot_al;
    first = pending_results.size();
    run_first = first;
    na = 1'b0;
    if (shaper_cfg.min_freq_al <= one &&
        (frac_below(a0, den_al, shaper_cfg.min_freq_al) ||
         frac_below(a1, den_al, shaper_cfg.min_freq_al)))
      na = 1'b1;
    if (shaper_cfg.min_freq_gt <= one &&
        (frac_below(g0, tot_gt, shaper_cfg.min_freq_gt) ||
         frac_below(g1, tot_gt, shaper_cfg.min_freq_gt) ||
         frac_below(g2, tot_gt, shaper_cfg.min_freq_gt)))
      na = 1'b1;
    if (shaper_cfg.section_mask[0]) begin
      if (shaper_cfg.absolute_mask[0]) begin
        add_result(g0, CODE_GT_HOMREF, KIND_ABS, na);
        add_result(g1, CODE_GT_HET, KIND_ABS, na);
        add_result(g2, CODE_GT_HOMALT, KIND_ABS, na);
      end else begin
        push_relative(g0, tot_gt, CODE_GT_HOMREF, na);
        push_relative(g1, tot_gt, CODE_GT_HET, na);
        push_relative(g2, tot_gt, CODE_GT_HOMALT, na);
        push_relative(g3, tot_gt, CODE_GT_MISSING, na);
      end
      if (shaper_cfg.include_totals) add_result(tot_gt, CODE_GT_TOTAL, KIND_ABS, na);
    end
    if (shaper_cfg.section_mask[1]) begin
      if (shaper_cfg.absolute_mask[1]) begin
        add_result(a0, CODE_AL_REF, KIND_ABS, na);
        add_result(a1, CODE_AL_ALT, KIND_ABS, na);
        add_result(a2, CODE_AL_MISSING, KIND_ABS, na);
      end else begin
        push_relative(a0, den_al, CODE_AL_REF, na);
        push_relative(a1, den_al, CODE_AL_ALT, na);
        push_relative(a2, tot_al, CODE_AL_MISSING, na);
      end
      if (shaper_cfg.include_totals) add_result(tot_al, CODE_AL_TOTAL, KIND_ABS, na);
    end
    if (pending_results.size() > first)
      pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  task automatic send_variant(input int unsigned h, input int unsigned t,
                              input int unsigned ha, input int unsigned m);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid    <= 1'b1;
    count_homref  <= COUNT_WIDTH'(h);
    count_het     <= COUNT_WIDTH'(t);
    count_homalt  <= COUNT_WIDTH'(ha);
    count_missing <= COUNT_WIDTH'(m);
    do @(posedge clk); while (item_stall);
    predict_frequencies(h, t, ha, m);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned data);
    @(negedge clk);
    item_valid <= 1'b0;
    cfg_valid  <= 1'b1;
    cfg_index  <= idx;
    cfg_data   <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Variants with no section selected leave nothing to wait for, so allow
  // the pipeline latency on top of the empty queue.
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    wait_idle();
    write_reg(REG_ABSOLUTE_MASK, 32'(c.absolute_mask));
    write_reg(REG_SECTION_MASK, 32'(c.section_mask));
    write_reg(REG_INCLUDE_TOTALS, 32'(c.include_totals));
    write_reg(REG_PERCENT_SCALE, 32'(c.percent_scale));
    write_reg(REG_EXTRAPOLATE, 32'(c.extrapolate));
    write_reg(REG_MIN_FREQ_AL, 32'(c.min_freq_al));
    write_reg(REG_MIN_FREQ_GT, 32'(c.min_freq_gt));
    shaper_cfg = c;
  endtask

  function automatic int unsigned pick_threshold();
    case ($urandom_range(5))
      0: return 0;
      1: return 65536;
      2: return 65537;
      3: return $urandom_range(65537);
      default: return $urandom_range(20000);
    endcase
  endfunction

  function automatic int unsigned pick_count();
    case ($urandom_range(9))
      0: return 0;
      1: return (1 << COUNT_WIDTH) - 1;
      2, 3: return $urandom_range((1 << COUNT_WIDTH) - 1);
      4: return $urandom_range(1000);
      default: return $urandom_range(20);
    endcase
  endfunction

  always @(negedge clk) begin
    result_stall <= rst ? 1'b0 : ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    freq_result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result code %0d value %0d", item_code, value));
      end else begin
        e = pending_results.pop_front();
        if (item_code !== e.code || value !== e.value || value_kind !== e.kind ||
            is_na !== e.na || last !== e.last)
          report($sformatf("code %0d/%0d value %0d/%0d kind %0d/%0d na %b/%b last %b/%b",
                           item_code, e.code, value, e.value, value_kind, e.kind,
                           is_na, e.na, last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    variant_row_t directed[] = '{
      '{0, 0, 0, 0, 1, 1'b1, 0},
      '{5, 0, 0, 0, 1, 1'b0, 65536},
      '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 1'b0, 16384},
      '{0, 0, 0, 7, 1, 1'b0, 0},
      '{0, 9, 0, 0, 1, 1'b0, 0},
      '{0, 0, 24'hFFFFFF, 0, 0, 1'b0, 0},
      '{24'hFFFFFF, 0, 0, 0, 1, 1'b0, 65536},
      '{1, 1, 1, 0, 0, 1'b0, 0},
      '{3, 2, 1, 1, 0, 1'b0, 0},
      '{24'h800000, 24'h000001, 24'h7FFFFF, 24'h555555, 0, 1'b0, 0},
      '{1, 0, 0, 24'hFFFFFF, 0, 1'b0, 0},
      '{1, 2, 3, 4, 0, 1'b0, 0}
    };
    cfg_t c;
    rst = 1'b1;
    item_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    count_homref = '0;
    count_het = '0;
    count_homalt = '0;
    count_missing = '0;
    shaper_cfg = '{absolute_mask: 2'd0, section_mask: 2'd1, include_totals: 1'b1,
                   percent_scale: 1'b0, extrapolate: 1'b1, min_freq_al: '0,
                   min_freq_gt: '0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed variants under the register defaults: the first result is the
    // homozygous reference fraction over the genotype total.
    foreach (directed[i]) begin
      send_variant(directed[i].homref, directed[i].het, directed[i].homalt,
                   directed[i].missing);
      if (directed[i].checked &&
          (pending_results[run_first].na !== directed[i].exp_na ||
           pending_results[run_first].value !== directed[i].exp_value))
        report($sformatf("directed row %0d predicted %0d na %b", i,
                         pending_results[run_first].value,
                         pending_results[run_first].na));
    end

    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct    = p < 5 ? 35 : (p < 10 ? 78 : 0);
      receiver_stall_pct = p < 5 ? 78 : (p < 10 ? 35 : 0);
      c.absolute_mask  = 2'($urandom_range(3));
      c.section_mask   = 2'($urandom_range(3));
      c.include_totals = 1'($urandom_range(1));
      c.percent_scale  = 1'($urandom_range(1));
      c.extrapolate    = 1'($urandom_range(1));
      c.min_freq_al    = THR_W'(pick_threshold());
      c.min_freq_gt    = THR_W'(pick_threshold());
      if (p == 0) begin
        c = '{absolute_mask: 2'd3, section_mask: 2'd3, include_totals: 1'b1,
              percent_scale: 1'b1, extrapolate: 1'b1, min_freq_al: 17'd65537,
              min_freq_gt: 17'd65536};
      end else if (p == 1) begin
        c = '{absolute_mask: 2'd0, section_mask: 2'd0, include_totals: 1'b0,
              percent_scale: 1'b0, extrapolate: 1'b0, min_freq_al: 17'd0,
              min_freq_gt: 17'd0};
      end else if (p == 2) begin
        c.section_mask = 2'd3;
        c.absolute_mask = 2'd0;
        c.percent_scale = 1'b1;
      end
      apply_cfg(c);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_variant(pick_count(), pick_count(), pick_count(), pick_count());
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/gafs_pkg.sv
src/gafs_front.sv
src/gafs_seq.sv
src/gafs_div.sv
src/genotype_allele_frequency_shaper.sv
src/gafs_checker.sv
tb/tb_genotype_allele_frequency_shaper.sv
